// ===== hw/rtl/srf_pkg.sv =====
// ----------------------------------------------------------------------------
// srf_pkg
// Shared constants and types for the short run filter with segment labels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srf_pkg;

   localparam int COUNT_BITS_DEF = 8;
   localparam int RUN_BITS_DEF   = 16;

   localparam int THRESH_BITS = 16;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd13;

   // result queue
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [QUEUE_LEVEL_BITS-1:0] level;
      logic                        room_one;
      logic                        room_two;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srf_run_eval.sv =====
// ----------------------------------------------------------------------------
// srf_run_eval
// Classifies one finished run as noise or kept and advances the segment label when a kept run changes the value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srf_run_eval #(
   parameter int COUNT_BITS = srf_pkg::COUNT_BITS_DEF,
   parameter int RUN_BITS   = srf_pkg::RUN_BITS_DEF
) (
   input  wire logic [COUNT_BITS-1:0]          run_value,
   input  wire logic [RUN_BITS-1:0]            run_length,
   input  wire logic [COUNT_BITS-1:0]          kept_value,
   input  wire logic [RUN_BITS-1:0]            seg_label,
   input  wire logic [srf_pkg::THRESH_BITS-1:0] threshold,
   output logic                                is_noise,
   output logic [COUNT_BITS-1:0]               kept_next,
   output logic [RUN_BITS-1:0]                 seg_next
);

   localparam int CMP_W = (RUN_BITS > srf_pkg::THRESH_BITS) ? RUN_BITS : srf_pkg::THRESH_BITS;
   localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

   logic advance;

   always_comb begin
      is_noise  = CMP_W'(run_length) <= CMP_W'(threshold);
      advance   = !is_noise && (run_value != kept_value);
      kept_next = advance ? run_value : kept_value;
      if (advance && (seg_label != RUN_MAX)) begin
         seg_next = seg_label + RUN_BITS'(1);
      end else begin
         seg_next = seg_label;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srf_run_core.sv =====
// ----------------------------------------------------------------------------
// srf_run_core
// Request register plus run tracking state; emits up to two run records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srf_run_core #(
   parameter int COUNT_BITS = srf_pkg::COUNT_BITS_DEF,
   parameter int RUN_BITS   = srf_pkg::RUN_BITS_DEF,
   parameter int ENTRY_W    = COUNT_BITS + 2 * RUN_BITS + 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic [COUNT_BITS-1:0]           req_count,
   input  wire logic                            req_final,
   output logic                                 req_ready,
   input  wire logic [srf_pkg::THRESH_BITS-1:0] threshold,
   input  wire srf_pkg::queue_status_type       status,
   output logic [1:0]                           push_count,
   output logic [ENTRY_W-1:0]                   push_data0,
   output logic [ENTRY_W-1:0]                   push_data1
);

   localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

   // request register
   logic                  s1_valid_ff, s1_valid_in;
   logic [COUNT_BITS-1:0] s1_count_ff;
   logic                  s1_final_ff;

   // run state
   logic                  open_ff, open_in;
   logic [COUNT_BITS-1:0] value_ff, value_in;
   logic [RUN_BITS-1:0]   length_ff, length_in;
   logic [COUNT_BITS-1:0] kept_ff, kept_in;
   logic [RUN_BITS-1:0]   seg_ff, seg_in;

   logic                  emit_old;
   logic [1:0]            need;
   logic                  fire;
   logic                  accept;

   logic [COUNT_BITS-1:0] new_value;
   logic [RUN_BITS-1:0]   new_length;
   logic [COUNT_BITS-1:0] new_kept;
   logic [RUN_BITS-1:0]   new_seg;

   logic                  noise0, noise1;
   logic [COUNT_BITS-1:0] kept0, kept1;
   logic [RUN_BITS-1:0]   seg0, seg1;
   logic [ENTRY_W-1:0]    entry0, entry1;

   srf_run_eval #(.COUNT_BITS(COUNT_BITS), .RUN_BITS(RUN_BITS)) u_eval_old (
      .run_value  (value_ff),
      .run_length (length_ff),
      .kept_value (kept_ff),
      .seg_label  (seg_ff),
      .threshold  (threshold),
      .is_noise   (noise0),
      .kept_next  (kept0),
      .seg_next   (seg0)
   );

   srf_run_eval #(.COUNT_BITS(COUNT_BITS), .RUN_BITS(RUN_BITS)) u_eval_last (
      .run_value  (new_value),
      .run_length (new_length),
      .kept_value (new_kept),
      .seg_label  (new_seg),
      .threshold  (threshold),
      .is_noise   (noise1),
      .kept_next  (kept1),
      .seg_next   (seg1)
   );

   always_comb begin
      emit_old = open_ff && (s1_count_ff != value_ff);
      need     = {1'b0, emit_old} + {1'b0, s1_final_ff};

      case (need)
         2'd2:    fire = s1_valid_ff && status.room_two;
         2'd1:    fire = s1_valid_ff && status.room_one;
         default: fire = s1_valid_ff;
      endcase

      req_ready = !s1_valid_ff || fire;
      accept    = req_valid && req_ready;

      // state after this element, before any end-of-sequence clear
      if (!open_ff) begin
         new_value  = s1_count_ff;
         new_length = RUN_BITS'(1);
         new_kept   = s1_count_ff;
         new_seg    = seg_ff;
      end else if (!emit_old) begin
         new_value  = value_ff;
         new_length = (length_ff == RUN_MAX) ? length_ff : length_ff + RUN_BITS'(1);
         new_kept   = kept_ff;
         new_seg    = seg_ff;
      end else begin
         new_value  = s1_count_ff;
         new_length = RUN_BITS'(1);
         new_kept   = kept0;
         new_seg    = seg0;
      end

      entry0 = {1'b0, noise0, seg0, length_ff, value_ff};
      entry1 = {1'b1, noise1, seg1, new_length, new_value};

      push_data0 = emit_old ? entry0 : entry1;
      push_data1 = entry1;
      push_count = fire ? need : 2'd0;

      s1_valid_in = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

      open_in   = open_ff;
      value_in  = value_ff;
      length_in = length_ff;
      kept_in   = kept_ff;
      seg_in    = seg_ff;
      if (fire) begin
         if (s1_final_ff) begin
            open_in   = 1'b0;
            value_in  = '0;
            length_in = '0;
            kept_in   = '0;
            seg_in    = RUN_BITS'(1);
         end else begin
            open_in   = 1'b1;
            value_in  = new_value;
            length_in = new_length;
            kept_in   = new_kept;
            seg_in    = new_seg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         open_ff     <= 1'b0;
         value_ff    <= '0;
         length_ff   <= '0;
         kept_ff     <= '0;
         seg_ff      <= RUN_BITS'(1);
      end else begin
         s1_valid_ff <= s1_valid_in;
         open_ff     <= open_in;
         value_ff    <= value_in;
         length_ff   <= length_in;
         kept_ff     <= kept_in;
         seg_ff      <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_count_ff <= req_count;
         s1_final_ff <= req_final;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srf_out_queue.sv =====
// ----------------------------------------------------------------------------
// srf_out_queue
// Small response queue; takes up to two records per cycle, gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srf_out_queue #(
   parameter int ENTRY_W = srf_pkg::COUNT_BITS_DEF + 2 * srf_pkg::RUN_BITS_DEF + 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         push_count,
   input  wire logic [ENTRY_W-1:0] push_data0,
   input  wire logic [ENTRY_W-1:0] push_data1,
   input  wire logic               pop,
   output logic                    head_valid,
   output logic [ENTRY_W-1:0]      head_data,
   output srf_pkg::queue_status_type status
);

   localparam int PTR_W = srf_pkg::QUEUE_PTR_BITS;
   localparam int LVL_W = srf_pkg::QUEUE_LEVEL_BITS;

   logic [ENTRY_W-1:0] mem_ff [srf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic               do_pop;

   always_comb begin
      head_valid = level_ff != '0;
      head_data  = mem_ff[rd_ptr_ff];
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      level_in  = level_ff + LVL_W'(push_count) - LVL_W'(do_pop);

      status.level    = level_ff;
      status.room_one = level_ff < LVL_W'(srf_pkg::QUEUE_DEPTH);
      status.room_two = level_ff < LVL_W'(srf_pkg::QUEUE_DEPTH - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push_data1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/short_run_filter_with_segment_label.sv =====
// A response becomes valid once the request closing its run has passed the request register
// and been written to the response queue. One request per cycle while the queue has room;
// the queue holds four records; a request closing two runs at once waits for two free slots.
// Reset (synchronous, active high): run state cleared, segment label back to 1,
// queue emptied, noise threshold back to 13.
// ----------------------------------------------------------------------------
// short_run_filter_with_segment_label
// Groups equal consecutive counts into runs, flags short runs as noise and
// labels kept segments; one response per finished run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module short_run_filter_with_segment_label #(
   parameter int COUNT_BITS = srf_pkg::COUNT_BITS_DEF,
   parameter int RUN_BITS   = srf_pkg::RUN_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // level_count
   input  wire logic [((COUNT_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  wire logic                                   req_tlast,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // run_value, run_length, segment_label
   output logic [((COUNT_BITS + 2 * RUN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // is_noise
   output logic                                        rsp_tuser,
   output logic                                        rsp_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic [srf_pkg::THRESH_BITS-1:0]        csr_data,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready
);

   localparam int RSP_BITS = ((COUNT_BITS + 2 * RUN_BITS + 7) / 8) * 8;
   localparam int DATA_W   = COUNT_BITS + 2 * RUN_BITS;
   localparam int ENTRY_W  = DATA_W + 2;

   logic [srf_pkg::THRESH_BITS-1:0] threshold_ff;
   srf_pkg::queue_status_type       status;
   logic [1:0]                      push_count;
   logic [ENTRY_W-1:0]              push_data0, push_data1;
   logic [ENTRY_W-1:0]              head_data;
   logic                            head_valid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= srf_pkg::THRESH_RESET;
      end else if (csr_valid) begin
         threshold_ff <= csr_data;
      end
   end

   srf_run_core #(
      .COUNT_BITS (COUNT_BITS),
      .RUN_BITS   (RUN_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_count  (req_tdata[COUNT_BITS-1:0]),
      .req_final  (req_tlast),
      .req_ready  (req_tready),
      .threshold  (threshold_ff),
      .status     (status),
      .push_count (push_count),
      .push_data0 (push_data0),
      .push_data1 (push_data1)
   );

   srf_out_queue #(.ENTRY_W(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .pop        (rsp_tready),
      .head_valid (head_valid),
      .head_data  (head_data),
      .status     (status)
   );

   // entry layout, low to high: value, length, label, noise, last
   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = RSP_BITS'(head_data[DATA_W-1:0]);
   assign rsp_tuser  = head_data[DATA_W];
   assign rsp_tlast  = head_data[DATA_W+1];

   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      status.level <= srf_pkg::QUEUE_LEVEL_BITS'(srf_pkg::QUEUE_DEPTH))
      else $error("response queue overfilled");

   a_label_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (head_data[2*RUN_BITS+COUNT_BITS-1:RUN_BITS+COUNT_BITS] != '0))
      else $error("segment label is zero");

   a_length_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (head_data[RUN_BITS+COUNT_BITS-1:COUNT_BITS] != '0))
      else $error("run length is zero");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> status.room_one)
      else $error("push into full response queue");

endmodule

`default_nettype wire
